// ===== rtl/core/ecf_pkg.sv =====
// ----------------------------------------------------------------------------
// ecf_pkg
// shared types, widths and codes of the electrode compensation fir unit
// ----------------------------------------------------------------------------
package ecf_pkg;

    localparam int MAX_TAPS    = 64;
    localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
    localparam int LEN_W       = $clog2(MAX_TAPS + 1);

    localparam int REQ_W       = 2;
    localparam int TAP_COUNT_W = 7;
    localparam int TAP_W       = 32;
    localparam int CUR_W       = 16;
    localparam int VOLT_W      = 24;

    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ENABLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = CFG_IDX_W'(1);

    localparam int PROD_W      = TAP_W + CUR_W;
    localparam int ACC_W       = PROD_W + TAP_IDX_W + 1;
    localparam int FIN_W       = ACC_W + 2;
    localparam int FRAC_BITS   = 16;
    localparam int ROUND_HALF  = 32768;
    localparam int OUT_MAX     = 8388607;
    localparam int OUT_MIN     = -8388608;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_INIT   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic                       enable;
        logic [LEN_W-1:0]           len;
        logic [TAP_IDX_W-1:0]       tap_index;
        logic signed [TAP_W-1:0]    tap_value;
        logic signed [CUR_W-1:0]    current_pa;
        logic signed [VOLT_W-1:0]   voltage_uv;
    } entry_t;

endpackage

// ===== rtl/core/ecf_front.sv =====
// ----------------------------------------------------------------------------
// ecf_front
// configuration registers, request decode and queue entry build
// ----------------------------------------------------------------------------
module ecf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ecf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ecf_pkg::REQ_W-1:0]           s_req_type,
    input  logic [ecf_pkg::TAP_IDX_W-1:0]       s_tap_index,
    input  logic signed [ecf_pkg::TAP_W-1:0]    s_tap_value,
    input  logic signed [ecf_pkg::CUR_W-1:0]    s_current_pa,
    input  logic signed [ecf_pkg::VOLT_W-1:0]   s_voltage_uv,
    output logic                                push_valid,
    input  logic                                push_ready,
    output ecf_pkg::entry_t                     push_entry
);

    logic                                kernel_enable_reg;
    logic [ecf_pkg::TAP_COUNT_W-1:0]     tap_count_reg;
    logic [ecf_pkg::LEN_W-1:0]           len_in_use;
    ecf_pkg::op_t                        op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_enable_reg <= 1'b0;
            tap_count_reg     <= ecf_pkg::TAP_COUNT_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                ecf_pkg::REG_KERNEL_ENABLE: kernel_enable_reg <= cfg_data[0];
                ecf_pkg::REG_TAP_COUNT: tap_count_reg <= cfg_data[ecf_pkg::TAP_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the maximum as the maximum
    always_comb begin
        if (tap_count_reg == '0) begin
            len_in_use = ecf_pkg::LEN_W'(1);
        end else if (32'(tap_count_reg) > ecf_pkg::MAX_TAPS) begin
            len_in_use = ecf_pkg::LEN_W'(ecf_pkg::MAX_TAPS);
        end else begin
            len_in_use = ecf_pkg::LEN_W'(tap_count_reg);
        end
    end

    assign op = ecf_pkg::op_t'(s_req_type);

    // the unused request code (OP_NONE) is taken and dropped here
    assign s_ready    = push_ready;
    assign push_valid = s_valid && (op != ecf_pkg::OP_NONE);

    always_comb begin
        push_entry.op         = op;
        push_entry.enable     = kernel_enable_reg;
        push_entry.len        = len_in_use;
        push_entry.tap_index  = s_tap_index;
        push_entry.tap_value  = s_tap_value;
        push_entry.current_pa = s_current_pa;
        push_entry.voltage_uv = s_voltage_uv;
    end

endmodule

// ===== rtl/core/ecf_queue.sv =====
// ----------------------------------------------------------------------------
// ecf_queue
// short fifo between decode and execution
// ----------------------------------------------------------------------------
module ecf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ecf_pkg::entry_t in_entry,
    output logic            out_valid,
    input  logic            out_ready,
    output ecf_pkg::entry_t out_entry
);

    ecf_pkg::entry_t                  slot_reg [ecf_pkg::QUEUE_DEPTH];
    logic [ecf_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ecf_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ecf_pkg::QCNT_W-1:0]       count_reg;
    logic                             push;
    logic                             pop;

    assign in_ready  = (count_reg != ecf_pkg::QCNT_W'(ecf_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == ecf_pkg::QPTR_W'(ecf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == ecf_pkg::QPTR_W'(ecf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ===== rtl/core/ecf_back.sv =====
// ----------------------------------------------------------------------------
// ecf_back
// kernel and history stores, multiply-accumulate loop and result register
// ----------------------------------------------------------------------------
module ecf_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  ecf_pkg::entry_t                     q_entry,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ecf_pkg::VOLT_W-1:0]   m_compensated_uv
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_NORM,
        S_MAC,
        S_SUM,
        S_EMIT
    } state_t;

    state_t                                 state_reg;
    ecf_pkg::entry_t                        item_reg;

    logic signed [ecf_pkg::TAP_W-1:0]       kernel_mem [ecf_pkg::MAX_TAPS];
    logic signed [ecf_pkg::CUR_W-1:0]       hist_mem [ecf_pkg::MAX_TAPS];
    logic [ecf_pkg::MAX_TAPS-1:0]           hist_valid_reg;

    logic [ecf_pkg::TAP_IDX_W-1:0]          wpos_reg;
    logic [ecf_pkg::TAP_IDX_W-1:0]          pos_reg;
    logic [ecf_pkg::TAP_IDX_W-1:0]          kidx_reg;
    logic [ecf_pkg::TAP_IDX_W-1:0]          h_reg;
    logic [ecf_pkg::TAP_IDX_W-1:0]          fill_idx_reg;
    logic signed [ecf_pkg::VOLT_W-1:0]      delay0_reg;
    logic signed [ecf_pkg::VOLT_W-1:0]      delay1_reg;

    logic                                   rd_vld_reg;
    logic                                   prod_vld_reg;
    logic signed [ecf_pkg::TAP_W-1:0]       kern_rd_reg;
    logic signed [ecf_pkg::CUR_W-1:0]       hist_rd_reg;
    logic                                   hist_rd_vld_reg;
    logic signed [ecf_pkg::PROD_W-1:0]      prod_reg;
    logic signed [ecf_pkg::ACC_W-1:0]       acc_reg;

    logic                                   m_valid_reg;
    logic signed [ecf_pkg::VOLT_W-1:0]      calc_reg;
    logic signed [ecf_pkg::VOLT_W-1:0]      result_reg;

    logic                                   pop;
    logic                                   emit_fire;
    logic                                   sum_done;
    logic                                   hist_we;
    logic [ecf_pkg::TAP_IDX_W-1:0]          hist_waddr;
    logic [ecf_pkg::TAP_IDX_W-1:0]          pos_last;
    logic [ecf_pkg::LEN_W-1:0]              pos_inc;
    logic signed [ecf_pkg::CUR_W-1:0]       hist_word;
    logic signed [ecf_pkg::FIN_W-1:0]       fin_x;
    logic signed [ecf_pkg::FIN_W-1:0]       fin_q;
    logic signed [ecf_pkg::VOLT_W-1:0]      fin_sat;

    assign q_ready          = (state_reg == S_IDLE);
    assign pop              = q_valid && q_ready;
    assign emit_fire        = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign sum_done         = (state_reg == S_SUM) && !rd_vld_reg && !prod_vld_reg;
    assign m_valid          = m_valid_reg;
    assign m_compensated_uv = result_reg;

    assign hist_we    = (state_reg == S_FILL) || emit_fire;
    assign hist_waddr = (state_reg == S_FILL) ? fill_idx_reg : pos_reg;
    assign pos_last   = ecf_pkg::TAP_IDX_W'(item_reg.len - 1'b1);
    assign pos_inc    = ecf_pkg::LEN_W'(pos_reg) + 1'b1;
    assign hist_word  = hist_rd_vld_reg ? hist_rd_reg : '0;

    // rounding to nearest with ties upward, then saturation
    always_comb begin
        fin_x = (ecf_pkg::FIN_W'(delay0_reg) <<< ecf_pkg::FRAC_BITS)
              - ecf_pkg::FIN_W'(acc_reg)
              + ecf_pkg::FIN_W'(ecf_pkg::ROUND_HALF);
        fin_q = fin_x >>> ecf_pkg::FRAC_BITS;
        if (fin_q > ecf_pkg::FIN_W'(ecf_pkg::OUT_MAX)) begin
            fin_sat = ecf_pkg::VOLT_W'(ecf_pkg::OUT_MAX);
        end else if (fin_q < ecf_pkg::FIN_W'(ecf_pkg::OUT_MIN)) begin
            fin_sat = ecf_pkg::VOLT_W'(ecf_pkg::OUT_MIN);
        end else begin
            fin_sat = fin_q[ecf_pkg::VOLT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            hist_valid_reg <= '0;
            wpos_reg       <= '0;
            delay0_reg     <= '0;
            delay1_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            prod_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg   <= (state_reg == S_MAC);
            prod_vld_reg <= rd_vld_reg;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (hist_we) begin
                hist_valid_reg[hist_waddr] <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        case (q_entry.op)
                            ecf_pkg::OP_INIT: begin
                                wpos_reg   <= '0;
                                delay0_reg <= q_entry.voltage_uv;
                                delay1_reg <= q_entry.voltage_uv;
                                state_reg  <= S_FILL;
                            end
                            ecf_pkg::OP_SAMPLE: begin
                                state_reg <= S_NORM;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FILL: begin
                    if (fill_idx_reg == pos_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_NORM: begin
                    if (ecf_pkg::LEN_W'(pos_reg) < item_reg.len) begin
                        state_reg <= item_reg.enable ? S_MAC : S_EMIT;
                    end
                end
                S_MAC: begin
                    if (kidx_reg == pos_last) begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (sum_done) begin
                        delay0_reg <= delay1_reg;
                        delay1_reg <= item_reg.voltage_uv;
                        state_reg  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        wpos_reg    <= (pos_inc == item_reg.len) ?
                                       '0 : pos_inc[ecf_pkg::TAP_IDX_W-1:0];
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg     <= q_entry;
            pos_reg      <= wpos_reg;
            fill_idx_reg <= '0;
        end
        if (pop && q_entry.op == ecf_pkg::OP_LOAD) begin
            kernel_mem[q_entry.tap_index] <= q_entry.tap_value;
        end
        if (state_reg == S_FILL) begin
            fill_idx_reg <= fill_idx_reg + 1'b1;
        end
        if (hist_we) begin
            hist_mem[hist_waddr] <= item_reg.current_pa;
        end
        if (state_reg == S_NORM) begin
            if (ecf_pkg::LEN_W'(pos_reg) >= item_reg.len) begin
                pos_reg <= pos_reg - ecf_pkg::TAP_IDX_W'(item_reg.len);
            end else begin
                kidx_reg <= '0;
                h_reg    <= (pos_reg == '0) ? pos_last : pos_reg - 1'b1;
                acc_reg  <= '0;
            end
        end
        if (state_reg == S_MAC) begin
            kidx_reg <= kidx_reg + 1'b1;
            h_reg    <= (h_reg == '0) ? pos_last : h_reg - 1'b1;
        end
        kern_rd_reg     <= kernel_mem[kidx_reg];
        hist_rd_reg     <= hist_mem[h_reg];
        hist_rd_vld_reg <= hist_valid_reg[h_reg];
        prod_reg        <= hist_word * kern_rd_reg;
        if (prod_vld_reg) begin
            acc_reg <= acc_reg + ecf_pkg::ACC_W'(prod_reg);
        end
        // result is staged here and only moves to the output at the emit beat
        if (state_reg == S_NORM && ecf_pkg::LEN_W'(pos_reg) < item_reg.len
                && !item_reg.enable) begin
            calc_reg <= item_reg.voltage_uv;
        end else if (sum_done) begin
            calc_reg <= fin_sat;
        end
        if (emit_fire) begin
            result_reg <= calc_reg;
        end
    end

    a_mac_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |->
            (ecf_pkg::LEN_W'(kidx_reg) < item_reg.len) && (ecf_pkg::LEN_W'(h_reg) < item_reg.len))
        else $error("mac index beyond taps in use");

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> (ecf_pkg::LEN_W'(fill_idx_reg) < item_reg.len))
        else $error("history fill beyond taps in use");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("mac pipeline busy while idle");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("emitted result not presented");

endmodule

// ===== rtl/core/electrode_compensation_fir_unit.sv =====
// ----------------------------------------------------------------------------
// electrode_compensation_fir_unit
// electrode artifact removal: fir of injected current history against a
// loaded impedance kernel, subtracted from the delayed measured voltage
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  s         in         s_valid/s_ready      s_req_type .. s_voltage_uv
//  m         out        m_valid/m_ready      m_compensated_uv
//
//  sample beat with compensation on: normalise, one multiply-accumulate per tap
//  through one kernel and one history port, sum, emit; with compensation off:
//  normalise, then emit; load beat: the kernel tap is written as it leaves the
//  queue; initialise beat: one history entry written per cycle; a stale write
//  position is brought into range by repeated subtraction of tap_count while
//  normalising; reset clears state at once, no clearing pass; a two-entry queue
//  lets input beats land while the back end works or a result waits on m_ready
// ----------------------------------------------------------------------------
module electrode_compensation_fir_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ecf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ecf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ecf_pkg::REQ_W-1:0]           s_req_type,
    input  logic [ecf_pkg::TAP_IDX_W-1:0]       s_tap_index,
    input  logic signed [ecf_pkg::TAP_W-1:0]    s_tap_value,
    input  logic signed [ecf_pkg::CUR_W-1:0]    s_current_pa,
    input  logic signed [ecf_pkg::VOLT_W-1:0]   s_voltage_uv,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ecf_pkg::VOLT_W-1:0]   m_compensated_uv
);

    logic            push_valid;
    logic            push_ready;
    ecf_pkg::entry_t push_entry;
    logic            q_valid;
    logic            q_ready;
    ecf_pkg::entry_t q_entry;

    ecf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_tap_index  (s_tap_index),
        .s_tap_value  (s_tap_value),
        .s_current_pa (s_current_pa),
        .s_voltage_uv (s_voltage_uv),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    ecf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    ecf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_entry          (q_entry),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_compensated_uv (m_compensated_uv)
    );

endmodule
